[hw/rtl/qbd_pkg.sv]
// Package: shared types, constants and functions for the block dequantizer.
`timescale 1ns / 1ps
package qbd_pkg;

  localparam int unsigned PosMax = 63;

  typedef enum logic [1:0] {
    FMT_Q4 = 2'd0,
    FMT_Q5 = 2'd1,
    FMT_Q8 = 2'd2,
    FMT_NONE = 2'd3
  } fmt_t;

  // one queued work entry: up to two codes against one scale
  typedef struct packed {
    logic [15:0] scale;
    logic        two;      // two results (packed nibbles)
    logic [5:0]  code_lo;  // signed code, first result
    logic [5:0]  code_hi;  // signed code, second result
    logic [8:0]  code8;    // signed eight-bit code (first result in Q8)
    logic [4:0]  index;
    logic        done_lo;
    logic        done_hi;
  } work_t;

  // stage result after the multiply
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic [17:0] prod;
    logic signed [6:0] ex;
  } mul_t;

  // Set up the exact product: magnitude times significand, registered after.
  function automatic mul_t mul_setup(input logic [15:0] h, input logic [8:0] code);
    mul_t r;
    logic s;
    logic [4:0] e;
    logic [9:0] m;
    logic cneg;
    logic [7:0] mag;
    logic [10:0] sig;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    cneg = code[8];
    mag = cneg ? 8'((~code) + 9'd1) : code[7:0];
    r.sign = s ^ cneg;
    r.special = 1'b0;
    r.special_val = 32'd0;
    if (e == 5'd31) begin
      r.special = 1'b1;
      if (m != 10'd0) r.special_val = {s, 8'hFF, 1'b1, m[8:0], 13'd0};
      else if (mag == 8'd0) r.special_val = 32'h7FC0_0000;
      else r.special_val = {r.sign, 8'hFF, 23'd0};
    end
    sig = (e == 5'd0) ? {1'b0, m} : {1'b1, m};
    r.ex = (e == 5'd0) ? -7'sd24 : $signed({2'b00, e}) - 7'sd25;
    r.prod = 18'(mag) * 18'(sig);
    return r;
  endfunction

  // Normalize the exact product into single format.
  function automatic logic [31:0] mul_pack(input mul_t r);
    logic [4:0] k;
    logic [7:0] ef;
    logic [40:0] sh;
    k = 5'd0;
    for (int i = 1; i < 18; i++) begin
      if (r.prod[i]) k = 5'(i);
    end
    ef = 8'($signed({{4{r.ex[6]}}, r.ex}) + $signed({6'd0, k}) + 11'sd127);
    sh = {23'd0, r.prod} << (5'd23 - k);
    if (r.special) return r.special_val;
    if (r.prod == 18'd0) return {r.sign, 31'd0};
    return {r.sign, ef, sh[22:0]};
  endfunction

endpackage

[hw/rtl/qbd_front.sv]
// Front end: tracks byte position, captures header, queues work entries.
`timescale 1ns / 1ps
module qbd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         block_format,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_start,
  output logic               wr_en,
  output qbd_pkg::work_t     wr_data,
  input  logic               q_full
);
  import qbd_pkg::*;

  logic [5:0]  byte_position;
  logic [15:0] scale_half;
  logic [31:0] high_bits_word;
  logic [5:0]  pos;
  logic [5:0]  hdr;
  logic [5:0]  cnt;
  logic [5:0]  j;
  logic        acc;
  logic        hb_lo, hb_hi;

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;
  assign pos = in_start ? 6'd0 : byte_position;
  assign hdr = (block_format == FMT_Q5) ? 6'd6 : 6'd2;
  assign cnt = (block_format == FMT_Q8) ? 6'd32 : 6'd16;
  assign j = pos - hdr;
  assign hb_lo = high_bits_word[j[4:0]];
  assign hb_hi = high_bits_word[{1'b1, j[3:0]}];

  always_comb begin
    wr_en = acc && block_format != FMT_NONE && pos >= hdr && j < cnt;
    wr_data.scale = scale_half;
    wr_data.two = block_format != FMT_Q8;
    wr_data.index = j[4:0];
    wr_data.code8 = {in_byte[7], in_byte};
    if (block_format == FMT_Q5) begin
      wr_data.code_lo = {1'b0, hb_lo, in_byte[3:0]} - 6'd16;
      wr_data.code_hi = {1'b0, hb_hi, in_byte[7:4]} - 6'd16;
    end else begin
      wr_data.code_lo = {2'b00, in_byte[3:0]} - 6'd8;
      wr_data.code_hi = {2'b00, in_byte[7:4]} - 6'd8;
    end
    wr_data.done_lo = (block_format == FMT_Q8) && j == 6'd31;
    wr_data.done_hi = j == 6'd15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      scale_half <= '0;
      high_bits_word <= '0;
    end else if (acc) begin
      byte_position <= (pos < 6'(PosMax)) ? pos + 6'd1 : 6'(PosMax);
      if (block_format != FMT_NONE) begin
        if (pos == 6'd0) scale_half[7:0] <= in_byte;
        else if (pos == 6'd1) scale_half[15:8] <= in_byte;
        else if (pos < hdr) high_bits_word[5'(pos - 6'd2) * 8 +: 8] <= in_byte;
      end
    end
  end
endmodule

[hw/rtl/qbd_fifo.sv]
// Small work queue between the front and back ends.
`timescale 1ns / 1ps
module qbd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  qbd_pkg::work_t wr_data,
  output logic           full,
  output logic           empty,
  input  logic           rd_en,
  output qbd_pkg::work_t rd_data
);
  import qbd_pkg::*;

  work_t      mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;

  assign full = count == 3'd4;
  assign empty = count == 3'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_en) wp <= wp + 2'd1;
      if (rd_en) rp <= rp + 2'd1;
      count <= count + 3'(wr_en) - 3'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !wr_en)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !rd_en)
    else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en && !full) |=> count == $past(count) + 3'd1)
    else $error("count mismatch");
endmodule

[hw/rtl/qbd_back.sv]
// Back end: per-result multiply stage, then normalize into an output register.
`timescale 1ns / 1ps
module qbd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           rd_en,
  input  qbd_pkg::work_t rd_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_value,
  output logic [4:0]     out_index,
  output logic           out_last,
  output logic           out_done
);
  import qbd_pkg::*;

  logic        half;       // 1: second result of current entry
  logic        s1_valid;
  mul_t        s1_mul;
  logic [4:0]  s1_index;
  logic        s1_last, s1_done;
  logic        s1_adv, issue;
  logic [8:0]  code;

  assign s1_adv = !out_valid || out_ready;
  assign issue = !q_empty && (!s1_valid || s1_adv);
  assign rd_en = issue && (!rd_data.two || half);
  assign code = !rd_data.two ? rd_data.code8
              : half ? {{3{rd_data.code_hi[5]}}, rd_data.code_hi}
                     : {{3{rd_data.code_lo[5]}}, rd_data.code_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      half <= 1'b0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) half <= rd_data.two && !half;
      if (issue) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_mul <= mul_setup(rd_data.scale, code);
      s1_index <= half ? rd_data.index + 5'd16 : rd_data.index;
      s1_last <= !rd_data.two || half;
      s1_done <= !rd_data.two ? rd_data.done_lo : (half && rd_data.done_hi);
    end
    if (s1_adv && s1_valid) begin
      out_value <= mul_pack(s1_mul);
      out_index <= s1_index;
      out_last <= s1_last;
      out_done <= s1_done;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_value))
    else $error("output changed while stalled");
  a_half_pair: assert property (@(posedge clk) disable iff (rst)
    (issue && half) |-> rd_en)
    else $error("second half did not pop");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> out_last)
    else $error("block done without run last");
endmodule

[hw/rtl/quant_block_dequantizer.sv]
// Top level of the quantized block dequantizer.
// Takes one byte per item (tdata = data_byte, tuser = block_start) and emits
// fp32 values (tdata = element_value, element_index; tuser = run_last,
// block_done). A code byte of the four/five-bit layouts yields two results,
// an eight-bit byte one; the back end has a single multiplier and issues one
// result per cycle, while work is queued and the output is not stalled, through
// a multiply stage and a normalize stage. A four-entry queue decouples byte
// intake from output stalls. block_format is written on cfg_valid/cfg_ready; the
// user must write it only while idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
module quant_block_dequantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] block_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] element_value, [36:32] element_index
  output logic [1:0]  m_axis_tuser    // [0] run_last, [1] block_done
);
  import qbd_pkg::*;

  logic [1:0]  block_format;
  logic        wr_en, q_full, q_empty, rd_en;
  work_t       wr_data, rd_data;
  logic [31:0] value;
  logic [4:0]  index;
  logic        last, done;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) block_format <= 2'd0;
    else if (cfg_valid) block_format <= cfg_data;
  end

  qbd_front u_front (
    .clk, .rst, .block_format,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_start(s_axis_tuser),
    .wr_en, .wr_data, .q_full
  );

  qbd_fifo u_fifo (
    .clk, .rst, .wr_en, .wr_data, .full(q_full), .empty(q_empty), .rd_en, .rd_data
  );

  qbd_back u_back (
    .clk, .rst, .q_empty, .rd_en, .rd_data,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_value(value), .out_index(index), .out_last(last), .out_done(done)
  );

  assign m_axis_tdata = {3'd0, index, value};
  assign m_axis_tuser = {done, last};
endmodule

[test/quant_block_dequantizer_tb.sv]
// Self-checking testbench for the quantized block dequantizer.
`timescale 1ns / 1ps
module quant_block_dequantizer_tb;
  import qbd_pkg::*;

  localparam int NumRandomBlocks = 50;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic [31:0] value;
    logic [4:0]  index;
    logic        last;
    logic        done;
  } elem_t;

  typedef struct {
    logic [7:0]  data;
    logic        start;
    logic        has_exp;
    logic [31:0] exp_val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  elem_t expected_elems[$];
  fmt_t  fmt_model;
  logic [5:0]  pos_model;
  logic [15:0] scale_model;
  logic [31:0] hiword_model;
  int mismatches = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  logic hold_off = 1'b0;
  logic bursty = 1'b1;

  quant_block_dequantizer dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact product of a signed code and an fp16 scale as an fp32 pattern.
  function automatic logic [31:0] scale_code(logic [15:0] h, int code);
    logic s;
    logic [4:0] e;
    logic [9:0] m;
    logic [31:0] mag, sig, prod, sgn;
    int ex, k;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    mag = (code < 0) ? -code : code;
    sgn = {s ^ (code < 0), 31'd0};
    if (e == 5'd31) begin
      if (m != 0) return {s, 8'hFF, 1'b1, m[8:0], 13'd0};
      if (mag == 0) return 32'h7FC0_0000;
      return sgn | 32'h7F80_0000;
    end
    sig = (e == 0) ? {22'd0, m} : {22'd1, m};
    ex = (e == 0) ? -24 : int'(e) - 25;
    prod = mag * sig;
    if (prod == 0) return sgn;
    k = 0;
    while ((prod >> (k + 1)) != 0) k++;
    return sgn | (32'(k + ex + 127) << 23) | ((prod << (23 - k)) & 32'h7F_FFFF);
  endfunction

  // Advance the model by one accepted byte and queue its results.
  task automatic predict_byte(logic [7:0] b, logic start);
    logic [5:0] pos;
    int hdr, count, j, lo, hi;
    elem_t el;
    pos = start ? 6'd0 : pos_model;
    pos_model = (pos < PosMax) ? pos + 6'd1 : 6'(PosMax);
    if (fmt_model == FMT_NONE) return;
    if (pos < 2) begin
      if (pos == 0) scale_model[7:0] = b;
      else scale_model[15:8] = b;
      return;
    end
    hdr = (fmt_model == FMT_Q5) ? 6 : 2;
    count = (fmt_model == FMT_Q8) ? 32 : 16;
    if (pos < hdr) begin
      hiword_model[(pos - 2) * 8 +: 8] = b;
      return;
    end
    j = pos - hdr;
    if (j >= count) return;
    if (fmt_model == FMT_Q8) begin
      el.value = scale_code(scale_model, int'($signed(b)));
      el.index = 5'(j); el.last = 1'b1; el.done = (j == 31);
      expected_elems.push_back(el);
      return;
    end
    if (fmt_model == FMT_Q4) begin
      lo = int'(b[3:0]) - 8;
      hi = int'(b[7:4]) - 8;
    end else begin
      lo = int'({hiword_model[j], b[3:0]}) - 16;
      hi = int'({hiword_model[j + 16], b[7:4]}) - 16;
    end
    el.value = scale_code(scale_model, lo);
    el.index = 5'(j); el.last = 1'b0; el.done = 1'b0;
    expected_elems.push_back(el);
    el.value = scale_code(scale_model, hi);
    el.index = 5'(j + 16); el.last = 1'b1; el.done = (j == 15);
    expected_elems.push_back(el);
  endtask

  // Keep tvalid up between back-to-back items; drop it only for a gap.
  task automatic send_byte(logic [7:0] b, logic start);
    if (bursty && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_byte(b, start);
    bytes_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_format(fmt_t f);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fmt_model = f;
  endtask

  // Send one block of the current format with the given scale.
  task automatic send_block(logic [15:0] scale, bit random_codes);
    int n;
    send_byte(scale[7:0], 1'b1);
    send_byte(scale[15:8], 1'b0);
    if (fmt_model == FMT_Q5) for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
    n = (fmt_model == FMT_Q8) ? 32 : 16;
    for (int i = 0; i < n; i++) send_byte(random_codes ? 8'($urandom) : 8'(i * 17), 1'b0);
  endtask

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 5'd31, 10'd0};
      1: return {1'($urandom), 5'd31, 10'($urandom_range(1, 1023))};
      2: return {1'($urandom), 5'd0, 10'($urandom)};
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stall pattern, with one long hold-off window.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    elem_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h/%b", m_axis_tdata, m_axis_tuser);
      end else begin
        want = expected_elems.pop_front();
        if (m_axis_tdata[31:0] !== want.value || m_axis_tdata[36:32] !== want.index ||
            m_axis_tuser[0] !== want.last || m_axis_tuser[1] !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp val %h idx %0d last %b done %b, got %h %0d %b %b",
                     want.value, want.index, want.last, want.done, m_axis_tdata[31:0],
                     m_axis_tdata[36:32], m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    fmt_model = FMT_Q4;
    pos_model = 0;
    scale_model = 0;
    hiword_model = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed Q4 rows: scale 1.0 (0x3C00); byte 0xF0 gives -8.0 then 7.0.
    rows.push_back('{8'h00, 1'b1, 1'b0, 32'h0});
    rows.push_back('{8'h3C, 1'b0, 1'b0, 32'h0});
    rows.push_back('{8'h08, 1'b0, 1'b1, 32'hC100_0000});
    rows.push_back('{8'h0F, 1'b0, 1'b1, 32'hC100_0000});
    rows.push_back('{8'hF0, 1'b0, 1'b1, 32'h40E0_0000});
    for (int i = 0; i < 13; i++) rows.push_back('{8'(i * 19), 1'b0, 1'b0, 32'h0});
    rows.push_back('{8'hAA, 1'b0, 1'b0, 32'h0});  // past end, ignored
    // infinite scale then code zero and nonzero
    rows.push_back('{8'h00, 1'b1, 1'b0, 32'h0});
    rows.push_back('{8'h7C, 1'b0, 1'b0, 32'h0});
    rows.push_back('{8'h88, 1'b0, 1'b1, 32'h7FC0_0000});
    rows.push_back('{8'h00, 1'b0, 1'b1, 32'hFF80_0000});
    foreach (rows[i]) begin
      r = rows[i];
      send_byte(r.data, r.start);
      // typed-in value for the final item of this byte
      if (r.has_exp) expected_elems[expected_elems.size() - 1].value = r.exp_val;
    end
    set_format(FMT_Q8);
    send_block(16'hFBFF, 1'b0);
    set_format(FMT_Q5);
    send_block(16'h8001, 1'b1);
    set_format(FMT_NONE);
    for (int i = 0; i < 8; i++) send_byte(8'($urandom), i == 0);
    // Long receiver hold-off while the sender keeps pushing.
    set_format(FMT_Q8);
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    send_block(16'h3C00, 1'b1);
    drain();
    for (int blk = 0; blk < NumRandomBlocks; blk++) begin
      bursty = ($urandom_range(0, 4) != 0);
      if (blk % 6 == 0) set_format(fmt_t'($urandom_range(0, 2)));
      if ($urandom_range(0, 9) == 0) begin
        // broken block or noise
        for (int i = 0; i < $urandom_range(1, 40); i++)
          send_byte(8'($urandom), ($urandom_range(0, 15) == 0));
      end else begin
        send_block(pick_scale(), 1'b1);
        // mid-block format change occasionally exercised via next block
      end
    end
    drain();
    $display("Sent %0d bytes, checked %0d values over all formats and scale classes.",
             bytes_sent, results_seen);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
hw/rtl/qbd_pkg.sv
hw/rtl/qbd_front.sv
hw/rtl/qbd_fifo.sv
hw/rtl/qbd_back.sv
hw/rtl/quant_block_dequantizer.sv
test/quant_block_dequantizer_tb.sv
